FILE: sv/rsmm_pkg.sv
// ----------------------------------------------------------------------------
// rsmm_pkg
// Shared constants, types and control structs for the rejection sampling
// modular multiply-accumulate block.
// ----------------------------------------------------------------------------
package rsmm_pkg;

  // Polynomial size and modulus.
  localparam int N_COEFFS = 256;
  localparam int MODULUS  = 7681;

  // Field widths of the item channels.
  localparam int OP_W      = 3;
  localparam int IDX_W     = 8;
  localparam int VAL_W     = 16;
  localparam int WORD_W    = 16;
  localparam int SMP_W     = 13;
  localparam int ACC_W     = 13;
  localparam int CNT_OUT_W = 9;

  // Derived storage and arithmetic widths.
  localparam int ADDR_W    = $clog2(N_COEFFS);
  localparam int CTR_W     = $clog2(N_COEFFS + 1);
  localparam int PROD_W    = VAL_W + SMP_W;
  localparam int SUM_W     = PROD_W + 1;

  // Barrett reduction of the sum: the quotient estimate is (sum * M) >> K with
  // M = floor(2^K / MODULUS). For any sum below 2^K it is the true quotient or
  // one less, so a single conditional subtract finishes the remainder.
  localparam int     BARRETT_K   = SUM_W;
  localparam longint BARRETT_M   = (longint'(1) << BARRETT_K) / MODULUS;
  localparam int     BARRETT_M_W = $clog2(BARRETT_M + 1);
  localparam int     QRAW_W      = SUM_W + BARRETT_M_W;
  localparam int     Q_W         = QRAW_W - BARRETT_K;
  // Reduction pipeline: estimate, quotient times modulus, subtract, correct.
  localparam int     RED_STEPS   = 4;
  localparam int     RED_CNT_W   = $clog2(RED_STEPS);

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CTR_W-1:0]       ctr_t;
  typedef logic [SMP_W-1:0]       smp_t;
  typedef logic [ACC_W-1:0]       acc_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [BARRETT_M_W-1:0] bm_t;
  typedef logic [QRAW_W-1:0]      qraw_t;
  typedef logic [Q_W-1:0]         q_t;
  typedef logic [RED_CNT_W-1:0]   red_cnt_t;
  typedef logic [CNT_OUT_W-1:0]   count_t;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_WR_OPD  = 3'd0,
    OP_WR_ACC  = 3'd1,
    OP_RD_ACC  = 3'd2,
    OP_RESTART = 3'd3,
    OP_SAMPLE  = 3'd4
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic wr_opd;
    logic wr_acc;
    logic rd_acc;
    logic rd_mac;
    logic clr_ctr;
    logic mul;
    logic red_init;
    logic red_step;
    logic wb;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mac_go;
    logic            red_last;
    logic            out_free;
  } sts_t;

endpackage

FILE: sv/rsmm_in_if.sv
// ----------------------------------------------------------------------------
// rsmm_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface rsmm_in_if;
  logic                       valid;
  logic                       ready;
  logic [rsmm_pkg::OP_W-1:0]   op;
  logic [rsmm_pkg::IDX_W-1:0]  index;
  logic [rsmm_pkg::VAL_W-1:0]  value;
  logic [rsmm_pkg::WORD_W-1:0] xof_word;

  modport source (output valid, op, index, value, xof_word, input ready);
  modport sink   (input valid, op, index, value, xof_word, output ready);
endinterface

FILE: sv/rsmm_out_if.sv
// ----------------------------------------------------------------------------
// rsmm_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface rsmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsmm_pkg::ACC_W-1:0]     read_value;
  logic                          accepted;
  logic                          row_done;
  logic [rsmm_pkg::CNT_OUT_W-1:0] count;

  modport source (output valid, read_value, accepted, row_done, count, input ready);
  modport sink   (input valid, read_value, accepted, row_done, count, output ready);
endinterface

FILE: sv/rsmm_ctrl.sv
// ----------------------------------------------------------------------------
// rsmm_ctrl
// Controller state machine: sequences decode, multiply, reduction,
// write-back and result hand-off for one transaction at a time.
// ----------------------------------------------------------------------------
module rsmm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsmm_pkg::sts_t sts,
  output rsmm_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DEC  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_ADD  = 7'b0001000,
    ST_RED  = 7'b0010000,
    ST_WB   = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = ST_DONE;
        unique case (sts.op)
          rsmm_pkg::OP_WR_OPD:  cmd.wr_opd  = 1'b1;
          rsmm_pkg::OP_WR_ACC:  cmd.wr_acc  = 1'b1;
          rsmm_pkg::OP_RD_ACC:  cmd.rd_acc  = 1'b1;
          rsmm_pkg::OP_RESTART: cmd.clr_ctr = 1'b1;
          rsmm_pkg::OP_SAMPLE: begin
            if (sts.mac_go) begin
              cmd.rd_mac = 1'b1;
              state_nxt  = ST_MUL;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.red_init = 1'b1;
        state_nxt    = ST_RED;
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/rsmm_dpath.sv
// ----------------------------------------------------------------------------
// rsmm_dpath
// Datapath: item registers, operand and accumulator memories, multiplier,
// pipelined Barrett modular reduction, coefficient counter and result register.
// ----------------------------------------------------------------------------
module rsmm_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rsmm_pkg::OP_W-1:0]   in_op,
  input  logic [rsmm_pkg::IDX_W-1:0]  in_index,
  input  logic [rsmm_pkg::VAL_W-1:0]  in_value,
  input  logic [rsmm_pkg::WORD_W-1:0] in_xof_word,
  input  rsmm_pkg::cmd_t              cmd,
  output rsmm_pkg::sts_t              sts,
  rsmm_out_if.source                  out_chan
);

  // Latched transaction fields.
  logic [rsmm_pkg::OP_W-1:0]  op_r;
  logic [rsmm_pkg::IDX_W-1:0] idx_r;
  logic [rsmm_pkg::VAL_W-1:0] val_r;
  rsmm_pkg::smp_t             smp_r;

  // Memories and their registered read data.
  logic [rsmm_pkg::VAL_W-1:0] opd_mem [rsmm_pkg::N_COEFFS];
  rsmm_pkg::acc_t             acc_mem [rsmm_pkg::N_COEFFS];
  logic [rsmm_pkg::VAL_W-1:0] opd_rd_r;
  rsmm_pkg::acc_t             acc_rd_r;

  // Arithmetic and control registers.
  rsmm_pkg::prod_t    prod_r;
  rsmm_pkg::sum_t     sum_r;
  rsmm_pkg::qraw_t    qraw_r;
  rsmm_pkg::sum_t     qm_r;
  rsmm_pkg::sum_t     diff_r;
  rsmm_pkg::acc_t     rem_r;
  rsmm_pkg::red_cnt_t red_cnt_r;
  rsmm_pkg::ctr_t     ctr_r;
  logic               hit_r;
  logic               accepted_r;
  logic               out_valid_r;
  rsmm_pkg::acc_t     out_rd_r;
  logic               out_acc_r;
  logic               out_done_r;
  rsmm_pkg::count_t   out_cnt_r;

  logic            idx_ok;
  logic            row_full;
  rsmm_pkg::addr_t idx_addr;
  rsmm_pkg::addr_t ctr_addr;
  rsmm_pkg::q_t    q_est;
  logic            acc_wr_en;
  rsmm_pkg::addr_t acc_wr_addr;
  rsmm_pkg::acc_t  acc_wr_data;
  logic            acc_rd_en;
  rsmm_pkg::addr_t acc_rd_addr;

  assign idx_ok   = (32'(idx_r) < rsmm_pkg::N_COEFFS);
  assign row_full = (ctr_r == rsmm_pkg::ctr_t'(rsmm_pkg::N_COEFFS));
  assign idx_addr = rsmm_pkg::addr_t'(idx_r);
  assign ctr_addr = rsmm_pkg::addr_t'(ctr_r);

  // Capture the transaction at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_op;
      idx_r <= in_index;
      val_r <= in_value;
      smp_r <= in_xof_word[rsmm_pkg::SMP_W-1:0];
    end
  end

  // Operand memory: written by the host, read at the counter for a sample.
  always_ff @(posedge clk) begin
    if (cmd.wr_opd && idx_ok) begin
      opd_mem[idx_addr] <= val_r;
    end
    if (cmd.rd_mac) begin
      opd_rd_r <= opd_mem[ctr_addr];
    end
  end

  // Accumulator memory port selection.
  assign acc_wr_en   = (cmd.wr_acc && idx_ok) || cmd.wb;
  assign acc_wr_addr = cmd.wb ? ctr_addr : idx_addr;
  assign acc_wr_data = cmd.wb ? rem_r : val_r[rsmm_pkg::ACC_W-1:0];
  assign acc_rd_en   = cmd.rd_mac || cmd.rd_acc;
  assign acc_rd_addr = cmd.rd_mac ? ctr_addr : idx_addr;

  always_ff @(posedge clk) begin
    if (acc_wr_en) begin
      acc_mem[acc_wr_addr] <= acc_wr_data;
    end
    if (acc_rd_en) begin
      acc_rd_r <= acc_mem[acc_rd_addr];
    end
  end

  // Product of operand coefficient and sample.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= opd_rd_r * smp_r;
    end
  end

  assign q_est = qraw_r[rsmm_pkg::QRAW_W-1:rsmm_pkg::BARRETT_K];

  // Barrett reduction: every step advances all four stages, so the remainder
  // is final after the fourth step.
  always_ff @(posedge clk) begin
    if (cmd.red_init) begin
      sum_r     <= rsmm_pkg::sum_t'(acc_rd_r) + rsmm_pkg::sum_t'(prod_r);
      red_cnt_r <= rsmm_pkg::red_cnt_t'(rsmm_pkg::RED_STEPS - 1);
    end else if (cmd.red_step) begin
      qraw_r    <= sum_r * rsmm_pkg::bm_t'(rsmm_pkg::BARRETT_M);
      qm_r      <= q_est * rsmm_pkg::acc_t'(rsmm_pkg::MODULUS);
      diff_r    <= sum_r - qm_r;
      rem_r     <= (diff_r >= rsmm_pkg::sum_t'(rsmm_pkg::MODULUS)) ?
                   rsmm_pkg::acc_t'(diff_r - rsmm_pkg::sum_t'(rsmm_pkg::MODULUS)) :
                   rsmm_pkg::acc_t'(diff_r);
      red_cnt_r <= red_cnt_r - rsmm_pkg::red_cnt_t'(1);
    end
  end

  // Coefficient counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.clr_ctr) begin
      ctr_r <= '0;
    end else if (cmd.wb) begin
      ctr_r <= ctr_r + rsmm_pkg::ctr_t'(1);
    end
  end

  // Per-transaction result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      accepted_r <= 1'b0;
    end else if (cmd.latch_in) begin
      hit_r      <= 1'b0;
      accepted_r <= 1'b0;
    end else if (cmd.rd_acc || cmd.rd_mac) begin
      hit_r      <= cmd.rd_acc && idx_ok;
      accepted_r <= cmd.rd_mac;
    end
  end

  // Output register decouples the result side from the input side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rd_r   <= hit_r ? acc_rd_r : '0;
      out_acc_r  <= accepted_r;
      out_done_r <= row_full;
      out_cnt_r  <= rsmm_pkg::count_t'(ctr_r);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = out_rd_r;
  assign out_chan.accepted   = out_acc_r;
  assign out_chan.row_done   = out_done_r;
  assign out_chan.count      = out_cnt_r;

  // Status toward the controller.
  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.mac_go   = (smp_r < rsmm_pkg::smp_t'(rsmm_pkg::MODULUS)) && !row_full;
    sts.red_last = (red_cnt_r == '0);
    sts.out_free = !out_valid_r || out_chan.ready;
  end

endmodule

FILE: sv/rejection_sample_mod_mac.sv
// ----------------------------------------------------------------------------
// rejection_sample_mod_mac: one transaction at a time, so a new item is taken
// only after the last result is loaded. An accumulated sample passes decode,
// multiply, add, Barrett reduction and write-back before the output register;
// other items pass decode only. A result still held there stalls the next one.
// Synchronous active-low reset clears the counter, controller and out valid.
// ----------------------------------------------------------------------------
module rejection_sample_mod_mac (
  input  logic        clk,
  input  logic        rst_n,
  rsmm_in_if.sink     in_chan,
  rsmm_out_if.source  out_chan
);

  rsmm_pkg::cmd_t cmd;
  rsmm_pkg::sts_t sts;
  logic           in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer.
  rsmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  rsmm_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_chan.op),
    .in_index    (in_chan.index),
    .in_value    (in_chan.value),
    .in_xof_word (in_chan.xof_word),
    .cmd         (cmd),
    .sts         (sts),
    .out_chan    (out_chan)
  );

endmodule
